// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel and window column types, frame size limits, register codes.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W   = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    // register fields as written
    localparam int IMG_WIDTH_FIELD_W  = 11;
    localparam int IMG_HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W         = 13;
    localparam int CFG_IDX_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam int WIDTH_RESET  = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int HEIGHT_RESET = 768;

    // beat kinds carried in tuser
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // one window column, oldest row on top
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } col_t;

endpackage

// ===== rtl/box_blur_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit: streaming 3x3 box blur on 8-bit rgb pixels
// Interior pixels become the truncated per-channel mean of their original
// 3x3 neighbourhood; border pixels pass through. Flush beats drain the tail.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata / data                 side band
//  s_axis    in         red, green, blue (lsb up)    tuser[0] = flush beat
//  m_axis    out        red, green, blue (lsb up)    tlast = last pixel of frame
//  cfg       in         index 0 width, 1 height      always ready
//
//  one beat per cycle in and out unless the output is held; results pass the
//  resolve stage and output register; pixel results trail input by width+1 beats
//  the stage between the line store reads and the output register only
//  stalls when it carries a result and the output register is held
//  reset clears counters, window and handshake state; line stores are not
//  cleared; a value read from them is always written before it is used in a frame
//  the user must write configuration only while no beat is in flight; the unit does not enforce it
//
module box_blur_3x3_rgb_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input pixel stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    input  logic [0:0]                     s_axis_tuser,  // action
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // red_out, green_out, blue_out
    output logic                           m_axis_tlast,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bb3_pkg::*;

    // control carried from acceptance into the resolve stage
    typedef struct packed {
        logic pixel;      // pixel beat: writes line stores, shifts window
        logic give;       // beat releases a result
        logic interior;   // result is the window mean
        logic frame_end;
        logic sel_lower;  // flush pass value from the lower store
        logic fwd_a;      // column reads hit the write in flight
        logic fwd_b;      // output column reads hit the write in flight
    } s1_ctrl_t;

    // frame size, kept clamped
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // position counters and backlog
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pending_reg, pending_next;

    // resolve stage
    logic       s1_valid_reg, s1_valid_next;
    s1_ctrl_t   s1_ctrl_reg,  s1_ctrl_next;
    pixel_t     s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t     fwd_up_reg;
    pixel_t     fwd_lo_reg;

    // output register
    logic       m_valid_reg, m_valid_next;
    pixel_t     m_data_reg;
    logic       m_last_reg;

    logic       s_accept;
    logic       s1_fire;
    logic       out_free;
    logic       is_flush;
    logic       past_line;
    logic       give_s0;
    logic       in_col_wrap;
    logic       out_col_wrap;
    logic [WIDTH_W-1:0]  in_col_p1;
    logic [HEIGHT_W-1:0] in_row_p1;
    logic [WIDTH_W-1:0]  out_col_p1;
    logic [HEIGHT_W-1:0] out_row_p1;
    pixel_t     pix_in;

    pixel_t     up_rd_a, up_rd_b, lo_rd_a, lo_rd_b;
    pixel_t     up_col, lo_col, pass_pix, mean_pix, result_pix;
    logic       store_wr;
    col_t       win_col;

    logic [IMG_WIDTH_FIELD_W-1:0]  width_field;
    logic [IMG_HEIGHT_FIELD_W-1:0] height_field;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign out_free      = !m_valid_reg || m_axis_tready;
    // a beat that releases nothing never waits on the output side
    assign s1_fire       = s1_valid_reg && (!s1_ctrl_reg.give || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign pix_in.red   = s_axis_tdata[7:0];
    assign pix_in.green = s_axis_tdata[15:8];
    assign pix_in.blue  = s_axis_tdata[23:16];

    // ------------------------------------------------------------------
    // configuration, clamped on write
    // ------------------------------------------------------------------
    assign width_field  = cfg_data[IMG_WIDTH_FIELD_W-1:0];
    assign height_field = cfg_data[IMG_HEIGHT_FIELD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(WIDTH_RESET);
            height_reg <= HEIGHT_W'(HEIGHT_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (width_field == '0) begin
                        width_reg <= WIDTH_W'(1);
                    end else if (width_field > MAX_WIDTH) begin
                        width_reg <= WIDTH_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= WIDTH_W'(width_field);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (height_field == '0) begin
                        height_reg <= HEIGHT_W'(1);
                    end else if (height_field > MAX_HEIGHT) begin
                        height_reg <= HEIGHT_W'(MAX_HEIGHT);
                    end else begin
                        height_reg <= HEIGHT_W'(height_field);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // acceptance: decide everything the counters settle
    // ------------------------------------------------------------------
    always_comb begin
        is_flush  = (s_axis_tuser[0] == ACT_FLUSH);
        // backlog beyond one line: the oldest pending pixel sits in the upper store
        past_line = pending_reg > PEND_W'(width_reg);
        give_s0   = is_flush ? (pending_reg != '0) : past_line;

        in_col_p1    = WIDTH_W'(in_col_reg) + WIDTH_W'(1);
        in_row_p1    = HEIGHT_W'(in_row_reg) + HEIGHT_W'(1);
        out_col_p1   = WIDTH_W'(out_col_reg) + WIDTH_W'(1);
        out_row_p1   = HEIGHT_W'(out_row_reg) + HEIGHT_W'(1);
        in_col_wrap  = in_col_p1 >= width_reg;
        out_col_wrap = out_col_p1 >= width_reg;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;

        if (s_accept) begin
            if (!is_flush) begin
                if (in_col_wrap) begin
                    in_col_next = '0;
                    in_row_next = (in_row_p1 >= height_reg) ? '0 : ROW_W'(in_row_p1);
                end else begin
                    in_col_next = COL_W'(in_col_p1);
                end
            end
            if (give_s0) begin
                if (out_col_wrap) begin
                    out_col_next = '0;
                    out_row_next = (out_row_p1 >= height_reg) ? '0 : ROW_W'(out_row_p1);
                end else begin
                    out_col_next = COL_W'(out_col_p1);
                end
            end
            if (is_flush && give_s0) begin
                pending_next = pending_reg - PEND_W'(1);
            end else if (!is_flush && !give_s0) begin
                pending_next = pending_reg + PEND_W'(1);
            end
        end

        s1_ctrl_next.pixel     = !is_flush;
        s1_ctrl_next.give      = give_s0;
        s1_ctrl_next.interior  = !is_flush
                                 && (out_row_reg != '0) && (out_row_p1 < height_reg)
                                 && (out_col_reg != '0) && (out_col_p1 < width_reg);
        s1_ctrl_next.frame_end = (out_row_p1 == height_reg) && (out_col_p1 == width_reg);
        s1_ctrl_next.sel_lower = !past_line;
        // the store write of the beat now leaving the resolve stage is not
        // yet visible to this cycle's reads
        s1_ctrl_next.fwd_a     = store_wr && (in_col_reg == s1_col_reg);
        s1_ctrl_next.fwd_b     = store_wr && (out_col_reg == s1_col_reg);

        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            pending_reg  <= pending_next;
            s1_valid_reg <= s1_valid_next;
            if (s_accept) begin
                s1_ctrl_reg <= s1_ctrl_next;
            end
        end
    end

    // resolve-stage payload, plus the write data it may have to stand in for
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= pix_in;
            s1_col_reg <= in_col_reg;
            fwd_up_reg <= lo_col;
            fwd_lo_reg <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // line stores: read at acceptance, written as the beat resolves
    // ------------------------------------------------------------------
    assign store_wr = s1_fire && s1_ctrl_reg.pixel;

    bb3_line_store u_upper_store (
        .aclk      (aclk),
        .wr_en     (store_wr),
        .wr_addr   (s1_col_reg),
        .wr_data   (lo_col),
        .rd_en     (s_accept),
        .rd_addr_a (in_col_reg),
        .rd_addr_b (out_col_reg),
        .rd_data_a (up_rd_a),
        .rd_data_b (up_rd_b)
    );

    bb3_line_store u_lower_store (
        .aclk      (aclk),
        .wr_en     (store_wr),
        .wr_addr   (s1_col_reg),
        .wr_data   (s1_pix_reg),
        .rd_en     (s_accept),
        .rd_addr_a (in_col_reg),
        .rd_addr_b (out_col_reg),
        .rd_data_a (lo_rd_a),
        .rd_data_b (lo_rd_b)
    );

    // ------------------------------------------------------------------
    // resolve stage
    // ------------------------------------------------------------------
    always_comb begin
        up_col   = s1_ctrl_reg.fwd_a ? fwd_up_reg : up_rd_a;
        lo_col   = s1_ctrl_reg.fwd_a ? fwd_lo_reg : lo_rd_a;
        if (s1_ctrl_reg.sel_lower) begin
            pass_pix = s1_ctrl_reg.fwd_b ? fwd_lo_reg : lo_rd_b;
        end else begin
            pass_pix = s1_ctrl_reg.fwd_b ? fwd_up_reg : up_rd_b;
        end
        win_col.top = up_col;
        win_col.mid = lo_col;
        win_col.bot = s1_pix_reg;
        result_pix  = s1_ctrl_reg.interior ? mean_pix : pass_pix;
    end

    bb3_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (store_wr),
        .col_in   (win_col),
        .mean_out (mean_pix)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        if (s1_fire && s1_ctrl_reg.give) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_ctrl_reg.give) begin
            m_data_reg <= result_pix;
            m_last_reg <= s1_ctrl_reg.frame_end;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_data_reg.blue, m_data_reg.green, m_data_reg.red};
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(MAX_WIDTH + 1))
        else $error("backlog beyond one line plus one pixel");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg != '0) && (width_reg <= WIDTH_W'(MAX_WIDTH)))
        else $error("frame width outside its clamped range");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted beat did not reach the resolve stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_ctrl_reg.give && m_valid_reg && !m_axis_tready
        |=> s1_valid_reg && s1_ctrl_reg.give)
        else $error("pending result dropped while output stalled");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_fire && s1_ctrl_reg.give))
        else $error("result appeared without a releasing beat");

endmodule

// ===== rtl/bb3_line_store.sv =====
// ----------------------------------------------------------------------------
// bb3_line_store: one row of pixels
// Single write port, two registered read ports, read-first on collision.
// ----------------------------------------------------------------------------
module bb3_line_store (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [bb3_pkg::COL_W-1:0] wr_addr,
    input  bb3_pkg::pixel_t      wr_data,
    input  logic                 rd_en,
    input  logic [bb3_pkg::COL_W-1:0] rd_addr_a,
    input  logic [bb3_pkg::COL_W-1:0] rd_addr_b,
    output bb3_pkg::pixel_t      rd_data_a,
    output bb3_pkg::pixel_t      rd_data_b
);
    import bb3_pkg::*;

    pixel_t mem [MAX_WIDTH];
    pixel_t rd_data_a_reg;
    pixel_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/bb3_window.sv =====
// ----------------------------------------------------------------------------
// bb3_window: 3x3 pixel window and its per-channel mean
// Shifts in one column per pixel; the mean covers the window after the shift.
// ----------------------------------------------------------------------------
module bb3_window (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  bb3_pkg::col_t   col_in,
    output bb3_pkg::pixel_t mean_out
);
    import bb3_pkg::*;

    localparam int SUM_W      = $clog2(9 * 255 + 1);
    localparam int PROD_W     = 2 * SUM_W;
    // floor(s / 9) = (s * 3641) >> 15 for every s up to 9 * 255
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    // the incoming column is the third one, so only two are held
    col_t  col_reg [2];
    sums_t sum_a;
    sums_t sum_b;
    sums_t sum_c;
    sums_t total;

    function automatic sums_t col_sum(input col_t c);
        sums_t s;
        s.red   = SUM_W'(c.top.red)   + SUM_W'(c.mid.red)   + SUM_W'(c.bot.red);
        s.green = SUM_W'(c.top.green) + SUM_W'(c.mid.green) + SUM_W'(c.bot.green);
        s.blue  = SUM_W'(c.top.blue)  + SUM_W'(c.mid.blue)  + SUM_W'(c.bot.blue);
        return s;
    endfunction

    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV9_MUL);
        return p[DIV9_SHIFT +: CHAN_W];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg[0] <= '0;
            col_reg[1] <= '0;
        end else if (shift_en) begin
            col_reg[0] <= col_reg[1];
            col_reg[1] <= col_in;
        end
    end

    always_comb begin
        sum_a       = col_sum(col_reg[0]);
        sum_b       = col_sum(col_reg[1]);
        sum_c       = col_sum(col_in);
        total.red   = sum_a.red   + sum_b.red   + sum_c.red;
        total.green = sum_a.green + sum_b.green + sum_c.green;
        total.blue  = sum_a.blue  + sum_b.blue  + sum_c.blue;
        mean_out.red   = div9(total.red);
        mean_out.green = div9(total.green);
        mean_out.blue  = div9(total.blue);
    end

endmodule
